// ----- design/gb3_pkg.sv -----
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types and constants of the 3x3 Gaussian blur stream unit.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int PixW          = 8;
  localparam int SumW          = 10;
  localparam int WeightW       = 9;
  localparam int ProdW         = WeightW + SumW;
  localparam int AccW          = 20;
  localparam int AccShift      = 8;
  localparam int FrameWidthW   = 11;
  localparam int FrameHeightW  = 13;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 13;
  localparam int WeightOne     = 256;

  localparam int DefMaxWidth   = 1024;
  localparam int DefMaxHeight  = 4096;
  localparam int RstFrameWidth  = 1024;
  localparam int RstFrameHeight = 1024;
  localparam int RstWeightCenter = 256;
  localparam int RstWeightEdge   = 0;
  localparam int RstWeightCorner = 0;

  localparam int ResFifoDepth  = 8;
  localparam int ResPtrW       = 3;
  localparam int ResCntW       = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth   = 3'd0,
    CfgFrameHeight  = 3'd1,
    CfgWeightCenter = 3'd2,
    CfgWeightEdge   = 3'd3,
    CfgWeightCorner = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [WeightW-1:0] center;
    logic [WeightW-1:0] edge_w;
    logic [WeightW-1:0] corner;
  } gb3_weights_t;

  typedef struct packed {
    logic [PixW-1:0] center;
    logic [SumW-1:0] edge_sum;
    logic [SumW-1:0] corner_sum;
    logic            last;
    logic            eof;
  } gb3_job_t;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            last;
    logic            eof;
  } gb3_res_t;

endpackage

// ----- design/gb3_line_mem.sv -----
// ----------------------------------------------------------------------------
// gb3_line_mem
// One line store: synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gb3_line_mem
  import gb3_pkg::*;
#(
  parameter int Depth = DefMaxWidth
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(Depth)-1:0]   rd_addr_i,
  output logic [PixW-1:0]            rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  logic [PixW-1:0]            wr_data_i
);

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/gb3_blur_lane.sv -----
// ----------------------------------------------------------------------------
// gb3_blur_lane
// Weighted sum of one 3x3 neighborhood: registered products, then
// sum, shift by 8 and saturation.
// ----------------------------------------------------------------------------
module gb3_blur_lane
  import gb3_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  gb3_job_t     job_i,
  input  gb3_weights_t weights_i,
  output logic         valid_o,
  output gb3_res_t     res_o
);

  logic             valid_q;
  logic [ProdW-1:0] prod_c_q, prod_e_q, prod_k_q;
  logic             last_q, eof_q;
  logic [AccW-1:0]  acc;
  logic [AccW-AccShift-1:0] acc_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_c_q <= ProdW'(weights_i.center) * ProdW'(job_i.center);
      prod_e_q <= ProdW'(weights_i.edge_w) * ProdW'(job_i.edge_sum);
      prod_k_q <= ProdW'(weights_i.corner) * ProdW'(job_i.corner_sum);
      last_q   <= job_i.last;
      eof_q    <= job_i.eof;
    end
  end

  always_comb begin
    acc    = AccW'(prod_c_q) + AccW'(prod_e_q) + AccW'(prod_k_q);
    acc_sh = acc[AccW-1:AccShift];
    res_o.pixel = (|acc_sh[AccW-AccShift-1:PixW]) ? {PixW{1'b1}} : acc_sh[PixW-1:0];
    res_o.last  = last_q;
    res_o.eof   = eof_q;
  end

  assign valid_o = valid_q;

endmodule

// ----- design/gb3_res_fifo.sv -----
// ----------------------------------------------------------------------------
// gb3_res_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module gb3_res_fifo
  import gb3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_a_i,
  input  gb3_res_t res_a_i,
  input  logic     push_b_i,
  input  gb3_res_t res_b_i,
  output logic     valid_o,
  output gb3_res_t res_o,
  input  logic     ready_i
);

  gb3_res_t           entry_q [ResFifoDepth];
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, addr_b;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign pop    = valid_o && ready_i;
  assign addr_b = push_a_i ? ResPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(push_a_i) + ResPtrW'(push_b_i);
    rd_ptr_d = rd_ptr_q + ResPtrW'(pop);
    cnt_d    = cnt_q + ResCntW'(push_a_i) + ResCntW'(push_b_i) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      entry_q[wr_ptr_q] <= res_a_i;
    end
    if (push_b_i) begin
      entry_q[addr_b] <= res_b_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign res_o   = entry_q[rd_ptr_q];

endmodule

// ----- design/gaussian_blur_3x3_stream_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_unit
// Path: a request's first result passes the S1 and lane product registers, then enters the output queue;
// a row-end request adds its second result in the same cycle, offered right behind it.
// Throughput: one request per cycle; stalls only during the clearing pass or while the result queue lacks room.
// Reset: a clearing pass over all MaxWidth line addresses zeroes both line stores;
// s_axis_tready stays low during it. Configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_unit
  import gb3_pkg::*;
#(
  parameter int MaxWidth  = DefMaxWidth,
  parameter int MaxHeight = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PixW-1:0]     s_axis_tdata,   // [7:0] pixel_in
  input  logic                s_axis_tuser,   // [0] kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // [7:0] pixel_out
  output logic                m_axis_tlast,
  output logic                m_axis_tuser    // [0] end_of_frame
);

  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight + 1);
  localparam int CmpW = 14;
  localparam int WidthLastRst =
    (RstFrameWidth > MaxWidth ? MaxWidth : RstFrameWidth) - 1;
  localparam int HeightRst =
    RstFrameHeight > MaxHeight ? MaxHeight : RstFrameHeight;

  // configuration, stored clamped
  logic [ColW-1:0] width_last_q;
  logic [RowW-1:0] height_q;
  gb3_weights_t    weights_q;
  logic [CmpW-1:0] cfg_w, cfg_h, w_clamp, h_clamp;
  logic [WeightW-1:0] cfg_wt;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_w = CmpW'(cfg_data_i[FrameWidthW-1:0]);
    cfg_h = CmpW'(cfg_data_i[FrameHeightW-1:0]);
    if (cfg_w < CmpW'(3)) begin
      w_clamp = CmpW'(3);
    end else if (cfg_w > CmpW'(MaxWidth)) begin
      w_clamp = CmpW'(MaxWidth);
    end else begin
      w_clamp = cfg_w;
    end
    if (cfg_h == '0) begin
      h_clamp = CmpW'(1);
    end else if (cfg_h > CmpW'(MaxHeight)) begin
      h_clamp = CmpW'(MaxHeight);
    end else begin
      h_clamp = cfg_h;
    end
    cfg_wt = (cfg_data_i[WeightW-1:0] > WeightW'(WeightOne)) ?
             WeightW'(WeightOne) : cfg_data_i[WeightW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q     <= ColW'(WidthLastRst);
      height_q         <= RowW'(HeightRst);
      weights_q.center <= WeightW'(RstWeightCenter);
      weights_q.edge_w <= WeightW'(RstWeightEdge);
      weights_q.corner <= WeightW'(RstWeightCorner);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrameWidth:   width_last_q     <= ColW'(w_clamp - CmpW'(1));
        CfgFrameHeight:  height_q         <= RowW'(h_clamp);
        CfgWeightCenter: weights_q.center <= cfg_wt;
        CfgWeightEdge:   weights_q.edge_w <= cfg_wt;
        CfgWeightCorner: weights_q.corner <= cfg_wt;
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic            clr_busy_q;
  logic [ColW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= ColW'(clr_addr_q + 1'b1);
      if (clr_addr_q == ColW'(MaxWidth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // request front end: position counters and result-slot reservation
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [ResCntW-1:0] resv_q, resv_d;
  logic               accept, end_row, end_frame, pop;

  assign s_axis_tready = !clr_busy_q && (resv_q <= ResCntW'(ResFifoDepth - 2));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign end_row       = col_q >= width_last_q;
  assign end_frame     = end_row && (row_q >= height_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_row) begin
        col_d = '0;
        row_d = (row_q >= height_q) ? '0 : RowW'(row_q + 1'b1);
      end else begin
        col_d = ColW'(col_q + 1'b1);
      end
    end
  end

  // S1 stage registers
  logic            s1_valid_q, s1_emit_q, s1_end_row_q, s1_end_frame_q;
  logic            s1_row0_q, s1_col0_q;
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] s1_pix_q;
  logic [1:0]      s1_release;

  always_comb begin
    s1_release = 2'd2;
    if (s1_emit_q) begin
      s1_release = s1_end_row_q ? 2'd0 : 2'd1;
    end
    resv_d = resv_q + (accept ? ResCntW'(2) : '0)
           - (s1_valid_q ? ResCntW'(s1_release) : '0)
           - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      resv_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      resv_q     <= resv_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q       <= col_q;
      s1_pix_q       <= (s_axis_tuser || row_q >= height_q) ? '0 : s_axis_tdata;
      s1_emit_q      <= (row_q != '0) && (col_q != '0);
      s1_end_row_q   <= end_row;
      s1_end_frame_q <= end_frame;
      s1_row0_q      <= (row_q == '0);
      s1_col0_q      <= (col_q == '0);
    end
  end

  // line stores
  logic [PixW-1:0] up_rd, mid_rd, up_wdata, mid_wdata;
  logic [ColW-1:0] wr_addr;
  logic            wr_en;

  always_comb begin
    wr_en     = clr_busy_q || s1_valid_q;
    wr_addr   = clr_busy_q ? clr_addr_q : s1_col_q;
    up_wdata  = (clr_busy_q || s1_row0_q) ? '0 : mid_rd;
    mid_wdata = clr_busy_q ? '0 : s1_pix_q;
  end

  gb3_line_mem #(.Depth(MaxWidth)) u_upper_line (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (up_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (up_wdata)
  );

  gb3_line_mem #(.Depth(MaxWidth)) u_middle_line (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (mid_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (mid_wdata)
  );

  // column window: 0..2 older column, 3..5 newer column (top, mid, bottom)
  logic [PixW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[0] <= s1_col0_q ? '0 : win_q[3];
      win_q[1] <= s1_col0_q ? '0 : win_q[4];
      win_q[2] <= s1_col0_q ? '0 : win_q[5];
      win_q[3] <= up_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= s1_pix_q;
    end
  end

  gb3_job_t job_a, job_b;

  always_comb begin
    job_a.center     = win_q[4];
    job_a.edge_sum   = SumW'(win_q[3]) + SumW'(win_q[5]) + SumW'(win_q[1]) + SumW'(mid_rd);
    job_a.corner_sum = SumW'(win_q[0]) + SumW'(win_q[2]) + SumW'(up_rd) + SumW'(s1_pix_q);
    job_a.last       = !s1_end_row_q;
    job_a.eof        = 1'b0;
    job_b.center     = mid_rd;
    job_b.edge_sum   = SumW'(up_rd) + SumW'(s1_pix_q) + SumW'(win_q[4]);
    job_b.corner_sum = SumW'(win_q[3]) + SumW'(win_q[5]);
    job_b.last       = 1'b1;
    job_b.eof        = s1_end_frame_q;
  end

  logic     lane_a_vld, lane_b_vld;
  gb3_res_t res_a, res_b, res_out;

  gb3_blur_lane u_lane_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q && s1_emit_q),
    .job_i     (job_a),
    .weights_i (weights_q),
    .valid_o   (lane_a_vld),
    .res_o     (res_a)
  );

  gb3_blur_lane u_lane_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q && s1_emit_q && s1_end_row_q),
    .job_i     (job_b),
    .weights_i (weights_q),
    .valid_o   (lane_b_vld),
    .res_o     (res_b)
  );

  gb3_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (lane_a_vld),
    .res_a_i  (res_a),
    .push_b_i (lane_b_vld),
    .res_b_i  (res_b),
    .valid_o  (m_axis_tvalid),
    .res_o    (res_out),
    .ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = res_out.pixel;
  assign m_axis_tlast = res_out.last;
  assign m_axis_tuser = res_out.eof;

endmodule
